[design/sha1s_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and round functions of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  // Geometry of the hash.
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;
  localparam int BLOCK_WORDS  = 16;
  localparam int COUNT_W      = 61;

  // Standard initial chaining values, entry 0 is the most significant word.
  localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Input word and result word of the two streaming channels.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Operations of the block buffer and message schedule.
  typedef enum logic [1:0] {
    SCH_NONE,
    SCH_BYTE,
    SCH_WORD,
    SCH_ROUND
  } sch_op_t;

  typedef struct packed {
    sch_op_t     op;
    logic [7:0]  byte_val;
    logic [1:0]  lane;
    logic [31:0] word;
  } sch_ctl_t;

  // Control of the shared round unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       reinit;
    logic [6:0] t;
  } rnd_ctl_t;

  // Round constant for round t.
  function automatic logic [31:0] sha1s_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // Boolean function for round t.
  function automatic logic [31:0] sha1s_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

[design/sha1_stream_hasher_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 over a byte stream, one optional byte per input word.
// ----------------------------------------------------------------------------
// Each input word may carry one message byte; a word marked last pads the
// message and returns the digest as five 32-bit result words, most
// significant first, after which a new message begins. The word carrying
// the 64th byte of a block stalls the input behind it while the single
// round unit runs the 80 rounds, one per cycle, and adds the result into
// the chain. A last word steps through the 0x80 byte, each padding word
// up to the length field, the two length words, one or two compressions
// and the loading of the five digest words, one at a time, into the output
// register, which waits for the output stall as needed. Input is accepted
// again once the fifth digest word is in the output register.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_core import sha1s_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_LENHI,
    S_LENLO,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  state_t          ret_r, ret_nxt;
  logic [5:0]      pos_r, pos_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [6:0]      t_r, t_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  sch_ctl_t        sch_ctl;
  rnd_ctl_t        rnd_ctl;
  logic [31:0]     wt;
  logic [31:0]     acc;
  logic [DIGEST_WORDS-1:0][31:0] chain;
  logic [63:0]     bit_len;
  logic            in_take;
  logic            out_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;
  assign bit_len  = {cnt_r, 3'b000};

  // Sequencer: byte intake, padding, compression and digest output.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    sch_ctl.op       = SCH_NONE;
    sch_ctl.byte_val = in_data.data_byte;
    sch_ctl.lane     = pos_r[1:0];
    sch_ctl.word     = 32'h0;

    rnd_ctl.load   = 1'b0;
    rnd_ctl.step   = 1'b0;
    rnd_ctl.fold   = 1'b0;
    rnd_ctl.reinit = 1'b0;
    rnd_ctl.t      = t_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.byte_present) begin
            sch_ctl.op = SCH_BYTE;
            pos_nxt    = pos_r + 6'd1;
            cnt_nxt    = cnt_r + COUNT_W'(1);
            if (pos_r == 6'd63) begin
              rnd_ctl.load = 1'b1;
              t_nxt        = 7'd0;
              state_nxt    = S_COMP;
              ret_nxt      = in_data.is_last ? S_PAD80 : S_IDLE;
            end else if (in_data.is_last) begin
              state_nxt = S_PAD80;
            end
          end else if (in_data.is_last) begin
            state_nxt = S_PAD80;
          end
        end
      end

      // The marker byte goes in like a message byte, but is not counted.
      S_PAD80: begin
        sch_ctl.op       = SCH_BYTE;
        sch_ctl.byte_val = PAD_BYTE;
        pos_nxt          = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          rnd_ctl.load = 1'b1;
          t_nxt        = 7'd0;
          state_nxt    = S_COMP;
          ret_nxt      = S_PADZ;
        end else begin
          state_nxt = S_PADZ;
        end
      end

      // Flush a partial word, then zero words up to the length field.
      S_PADZ: begin
        if (pos_r == 6'd56) begin
          state_nxt = S_LENHI;
        end else begin
          sch_ctl.op   = SCH_WORD;
          sch_ctl.word = (pos_r[1:0] == 2'd0) ? 32'h0 : acc;
          pos_nxt      = {pos_r[5:2] + 4'd1, 2'b00};
          if (pos_r[5:2] == 4'd15) begin
            rnd_ctl.load = 1'b1;
            t_nxt        = 7'd0;
            state_nxt    = S_COMP;
            ret_nxt      = S_PADZ;
          end
        end
      end

      S_LENHI: begin
        sch_ctl.op   = SCH_WORD;
        sch_ctl.word = bit_len[63:32];
        pos_nxt      = {pos_r[5:2] + 4'd1, 2'b00};
        state_nxt    = S_LENLO;
      end

      S_LENLO: begin
        sch_ctl.op   = SCH_WORD;
        sch_ctl.word = bit_len[31:0];
        pos_nxt      = 6'd0;
        rnd_ctl.load = 1'b1;
        t_nxt        = 7'd0;
        state_nxt    = S_COMP;
        ret_nxt      = S_EMIT;
        idx_nxt      = 3'd0;
      end

      // One round per cycle; the schedule rolls alongside.
      S_COMP: begin
        rnd_ctl.step = 1'b1;
        sch_ctl.op   = SCH_ROUND;
        t_nxt        = t_r + 7'd1;
        if (t_r == 7'(ROUNDS - 1)) begin
          state_nxt = S_FOLD;
        end
      end

      S_FOLD: begin
        rnd_ctl.fold = 1'b1;
        state_nxt    = ret_r;
      end

      // Digest words go out one at a time through the output register.
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = chain[idx_r];
          out_data_nxt.word_index  = idx_r;
          out_data_nxt.last_word   = (idx_r == 3'(DIGEST_WORDS - 1));
          idx_nxt                  = idx_r + 3'd1;
          if (idx_r == 3'(DIGEST_WORDS - 1)) begin
            rnd_ctl.reinit = 1'b1;
            cnt_nxt        = '0;
            pos_nxt        = 6'd0;
            idx_nxt        = 3'd0;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pos_r       <= 6'd0;
      cnt_r       <= '0;
      t_r         <= 7'd0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      t_r         <= t_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  sha1s_sched u_sched (
    .clk (clk),
    .ctl (sch_ctl),
    .wt  (wt),
    .acc (acc)
  );

  sha1s_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rnd_ctl),
    .wt    (wt),
    .chain (chain)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[design/sha1s_sched.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1s_sched
// Block buffer and rolling message schedule. Bytes gather big-endian in a
// word accumulator; finished words shift into a sixteen-word window, which
// then rolls one word per round during compression.
// ----------------------------------------------------------------------------
module sha1s_sched import sha1s_pkg::*; (
  input  wire logic        clk,
  input  wire sch_ctl_t    ctl,
  output logic [31:0]      wt,
  output logic [31:0]      acc
);

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [BLOCK_WORDS-1:0][31:0] win_r;
  logic [31:0] sched_word;

  // Place the byte in its lane, keeping the bytes above and clearing those below.
  always_comb begin
    case (ctl.lane)
      2'd0:    acc_nxt = {ctl.byte_val, 24'h0};
      2'd1:    acc_nxt = {acc_r[31:24], ctl.byte_val, 16'h0};
      2'd2:    acc_nxt = {acc_r[31:16], ctl.byte_val, 8'h0};
      default: acc_nxt = {acc_r[31:8], ctl.byte_val};
    endcase
  end

  // Next schedule word from the taps of the window.
  assign sched_word = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                       win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  // The window shifts towards entry zero whenever a word enters.
  always_ff @(posedge clk) begin
    case (ctl.op)
      SCH_BYTE: begin
        acc_r <= acc_nxt;
        if (ctl.lane == 2'd3) begin
          win_r <= {acc_nxt, win_r[BLOCK_WORDS-1:1]};
        end
      end
      SCH_WORD: begin
        win_r <= {ctl.word, win_r[BLOCK_WORDS-1:1]};
      end
      SCH_ROUND: begin
        win_r <= {sched_word, win_r[BLOCK_WORDS-1:1]};
      end
      default: begin
      end
    endcase
  end

  assign wt  = win_r[0];
  assign acc = acc_r;

endmodule
`default_nettype wire

[design/sha1s_round.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1s_round
// Shared SHA-1 round unit with the five chaining words. It runs one round
// per cycle on its working registers and folds them into the chain at the
// end of a block.
// ----------------------------------------------------------------------------
module sha1s_round import sha1s_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rnd_ctl_t                 ctl,
  input  wire logic [31:0]              wt,
  output logic [DIGEST_WORDS-1:0][31:0] chain
);

  logic [DIGEST_WORDS-1:0][31:0] chain_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt;

  // One round: rotated a, round function, e, constant and schedule word.
  assign a_nxt = {a_r[26:0], a_r[31:27]} + sha1s_f(ctl.t, b_r, c_r, d_r) + e_r
               + sha1s_k(ctl.t) + wt;

  // Chaining words: initial values at reset and after each digest, sums folded in at the end of a block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= H_INIT;
    end else if (ctl.reinit) begin
      chain_r <= H_INIT;
    end else if (ctl.fold) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctl.step) begin
      a_r <= a_nxt;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign chain = chain_r;

endmodule
`default_nettype wire
